// File: hw/rtl/bxd_pkg.sv
// Shared constants, types and helper functions of the box-average downscaler.
package bxd_pkg;

   // Build-time sizing
   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 1024;
   localparam int MAX_RATIO    = 8;
   localparam int CHANNEL_BITS = 8;

   // Fixed field widths of the ports
   localparam int PIX_W       = 8;
   localparam int CFG_W       = 11;
   localparam int RATIO_CFG_W = 4;
   localparam int CSR_IDX_W   = 2;

   // Derived widths
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int RAT_W  = $clog2(MAX_RATIO);
   localparam int SUM_W  = CHANNEL_BITS + 2 * RAT_W;
   localparam int CNT_W  = $clog2(MAX_RATIO * MAX_RATIO + 1);
   localparam int STEP_W = $clog2(SUM_W + 1);

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_RATIO  = CSR_IDX_W'(2);

   // Register reset values
   localparam logic [CFG_W-1:0]       WIDTH_RESET  = CFG_W'(1024);
   localparam logic [CFG_W-1:0]       HEIGHT_RESET = CFG_W'(1024);
   localparam logic [RATIO_CFG_W-1:0] RATIO_RESET  = RATIO_CFG_W'(2);

   localparam logic [SUM_W+PIX_W-1:0] CHAN_MASK = (SUM_W + PIX_W)'((64'd1 << CHANNEL_BITS) - 64'd1);

   // Three channel sums of one output column: index 0 red, 1 green, 2 blue
   typedef logic [2:0][SUM_W-1:0] bxd_sums_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // word accepted: latch pixel, read column sums
      logic update;    // accumulate, write back, advance position
      logic div_run;   // one divider step
      logic load_out;  // move quotients into the output register
   } bxd_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic emit;      // current pixel closes a block
      logic div_done;  // all quotient bits are done
      logic out_free;  // output register can take a new word
   } bxd_status_type;

   // Keep the used low bits of a channel, widened to a sum
   function automatic logic [SUM_W-1:0] chan_sum(input logic [PIX_W-1:0] v);
      logic [SUM_W+PIX_W-1:0] e;
      e = {{SUM_W{1'b0}}, v} & CHAN_MASK;
      return e[SUM_W-1:0];
   endfunction

   // Low byte of a quotient
   function automatic logic [PIX_W-1:0] out_byte(input logic [SUM_W-1:0] q);
      logic [SUM_W+PIX_W-1:0] e;
      e = {{PIX_W{1'b0}}, q};
      return e[PIX_W-1:0];
   endfunction

endpackage

// File: hw/rtl/bxd_if.sv
// Handshake interfaces of the downscaler: pixel input, averaged output, register writes.
interface bxd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;

   modport source(output valid, output red_in, output green_in, output blue_in, input ready);
   modport sink(input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface bxd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_avg;
   logic [7:0] green_avg;
   logic [7:0] blue_avg;
   logic       row_end;
   logic       image_end;

   modport source(output valid, output red_avg, output green_avg, output blue_avg,
                  output row_end, output image_end, input ready);
   modport sink(input valid, input red_avg, input green_avg, input blue_avg,
                input row_end, input image_end, output ready);
endinterface

interface bxd_csr_if import bxd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/bxd_ctrl.sv
// Controller state machine of the downscaler: sequences accept, update, divide, output.
module bxd_ctrl import bxd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  bxd_status_type status,
   output bxd_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_UPDATE = 3'b010,
      ST_DIVIDE = 3'b100
   } bxd_state_type;

   bxd_state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.emit ? ST_DIVIDE : ST_IDLE;
         end
         ST_DIVIDE: begin
            if (!status.div_done) begin
               cmd.div_run = 1'b1;
            end else if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/bxd_datapath.sv
// Datapath of the downscaler: registers, position counters, column sum memory, divider.
module bxd_datapath import bxd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // register writes
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   // pixel word
   input  logic [PIX_W-1:0]     red_in,
   input  logic [PIX_W-1:0]     green_in,
   input  logic [PIX_W-1:0]     blue_in,
   // control
   input  bxd_cmd_type          cmd,
   output bxd_status_type       status,
   // result word
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [PIX_W-1:0]     red_avg,
   output logic [PIX_W-1:0]     green_avg,
   output logic [PIX_W-1:0]     blue_avg,
   output logic                 row_end,
   output logic                 image_end
);

   // Configuration registers
   logic [CFG_W-1:0]       width_ff, width_in;
   logic [CFG_W-1:0]       height_ff, height_in;
   logic [RATIO_CFG_W-1:0] ratio_ff, ratio_in;
   logic                   restart;

   // Position counters
   logic [COL_W-1:0] pcol_ff, pcol_in;
   logic [ROW_W-1:0] prow_ff, prow_in;
   logic [RAT_W-1:0] cib_ff, cib_in;
   logic [RAT_W-1:0] rib_ff, rib_in;
   logic [COL_W-1:0] bcol_ff, bcol_in;

   // Clamped last positions
   logic [CFG_W-1:0]       width_m1, height_m1;
   logic [RATIO_CFG_W-1:0] ratio_m1;
   logic [COL_W-1:0]       w_last;
   logic [ROW_W-1:0]       h_last;
   logic [RAT_W-1:0]       r_last;
   logic                   last_col, last_row, col_done, row_done;

   // Accumulation
   bxd_sums_type sum_mem [MAX_WIDTH];
   bxd_sums_type rd_ff;
   bxd_sums_type pix_ff, pix_in;
   bxd_sums_type wr_in;
   logic         first;
   logic [CNT_W-1:0] cols, rows, n_in;

   // Divider
   logic [CNT_W-1:0]  n_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   bxd_sums_type      q_ff, q_in;
   logic [2:0][CNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W:0]    trial;
   logic              ge;
   logic              row_end_ff, image_end_ff;

   // Output register
   logic             out_valid_ff, out_valid_in;
   bxd_sums_type     avg_ff;
   logic             oend_row_ff, oend_img_ff;

   // Register writes; any known index restarts the image
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      ratio_in  = ratio_ff;
      restart   = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH: begin
               width_in = csr_data;
               restart  = 1'b1;
            end
            REG_IMAGE_HEIGHT: begin
               height_in = csr_data;
               restart   = 1'b1;
            end
            REG_BLOCK_RATIO: begin
               ratio_in = csr_data[RATIO_CFG_W-1:0];
               restart  = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   // Clamp registers to their legal range, as last positions
   always_comb begin
      width_m1  = width_ff - CFG_W'(1);
      height_m1 = height_ff - CFG_W'(1);
      ratio_m1  = ratio_ff - RATIO_CFG_W'(1);
      priority if (width_ff == '0)              w_last = '0;
      else if (32'(width_ff) > MAX_WIDTH)        w_last = COL_W'(MAX_WIDTH - 1);
      else                                       w_last = COL_W'(width_m1);
      priority if (height_ff == '0)             h_last = '0;
      else if (32'(height_ff) > MAX_HEIGHT)      h_last = ROW_W'(MAX_HEIGHT - 1);
      else                                       h_last = ROW_W'(height_m1);
      priority if (ratio_ff == '0)              r_last = '0;
      else if (32'(ratio_ff) > MAX_RATIO)        r_last = RAT_W'(MAX_RATIO - 1);
      else                                       r_last = RAT_W'(ratio_m1);
   end

   assign last_col    = (pcol_ff == w_last);
   assign last_row    = (prow_ff == h_last);
   assign col_done    = last_col || (cib_ff == r_last);
   assign row_done    = last_row || (rib_ff == r_last);
   assign status.emit = col_done && row_done;

   // New sums: the first pixel of a column's band starts from zero
   always_comb begin
      pix_in[0] = chan_sum(red_in);
      pix_in[1] = chan_sum(green_in);
      pix_in[2] = chan_sum(blue_in);
      first     = (cib_ff == '0) && (rib_ff == '0);
      for (int c = 0; c < 3; c++) begin
         wr_in[c] = (first ? '0 : rd_ff[c]) + pix_ff[c];
      end
      cols = CNT_W'(cib_ff) + CNT_W'(1);
      rows = CNT_W'(rib_ff) + CNT_W'(1);
      n_in = CNT_W'(cols * rows);
   end

   // Position advance in raster order
   always_comb begin
      pcol_in = pcol_ff;
      prow_in = prow_ff;
      cib_in  = cib_ff;
      rib_in  = rib_ff;
      bcol_in = bcol_ff;
      if (restart) begin
         pcol_in = '0;
         prow_in = '0;
         cib_in  = '0;
         rib_in  = '0;
         bcol_in = '0;
      end else if (cmd.update) begin
         if (last_col) begin
            pcol_in = '0;
            cib_in  = '0;
            bcol_in = '0;
            if (last_row) begin
               prow_in = '0;
               rib_in  = '0;
            end else begin
               prow_in = prow_ff + ROW_W'(1);
               rib_in  = (rib_ff == r_last) ? '0 : rib_ff + RAT_W'(1);
            end
         end else begin
            pcol_in = pcol_ff + COL_W'(1);
            if (cib_ff == r_last) begin
               cib_in  = '0;
               bcol_in = bcol_ff + COL_W'(1);
            end else begin
               cib_in = cib_ff + RAT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         ratio_ff  <= RATIO_RESET;
         pcol_ff   <= '0;
         prow_ff   <= '0;
         cib_ff    <= '0;
         rib_ff    <= '0;
         bcol_ff   <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         ratio_ff  <= ratio_in;
         pcol_ff   <= pcol_in;
         prow_ff   <= prow_in;
         cib_ff    <= cib_in;
         rib_ff    <= rib_in;
         bcol_ff   <= bcol_in;
      end
   end

   // Column sum memory: read on accept, write back on update
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_ff  <= sum_mem[bcol_ff];
         pix_ff <= pix_in;
      end
      if (cmd.update) begin
         sum_mem[bcol_ff] <= wr_in;
      end
   end

   // Restoring divider, one quotient bit per step for all three channels
   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      trial   = '0;
      ge      = 1'b0;
      if (cmd.update && status.emit) begin
         q_in    = wr_in;
         rem_in  = '0;
         step_in = '0;
      end else if (cmd.div_run) begin
         step_in = step_ff + STEP_W'(1);
         for (int c = 0; c < 3; c++) begin
            trial     = {rem_ff[c], q_ff[c][SUM_W-1]};
            ge        = (trial >= {1'b0, n_ff});
            q_in[c]   = {q_ff[c][SUM_W-2:0], ge};
            rem_in[c] = ge ? CNT_W'(trial - {1'b0, n_ff}) : CNT_W'(trial);
         end
      end
   end

   assign status.div_done = (step_ff == STEP_W'(SUM_W));

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      if (cmd.update && status.emit) begin
         n_ff         <= n_in;
         row_end_ff   <= last_col;
         image_end_ff <= last_col && last_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_W'(SUM_W);
      end else begin
         step_ff <= step_in;
      end
   end

   // Output register
   assign status.out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         avg_ff      <= q_ff;
         oend_row_ff <= row_end_ff;
         oend_img_ff <= image_end_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign red_avg   = out_byte(avg_ff[0]);
   assign green_avg = out_byte(avg_ff[1]);
   assign blue_avg  = out_byte(avg_ff[2]);
   assign row_end   = oend_row_ff;
   assign image_end = oend_img_ff;

endmodule

// File: hw/rtl/box_average_downscaler_core.sv
// Top level of the box-average downscaler: controller, datapath and channel wiring.
//
// Shrinks an RGB raster image by an integer block ratio (1 to 8): each block of
// ratio by ratio pixels becomes one output word holding the truncated per-channel
// mean, with partial blocks at the right and bottom edges averaged over the pixels
// they contain; row_end and image_end mark the last block of an output row and of
// the image. Pixels are taken one at a time: a pixel that does not close a block
// goes through a column sum memory read, then an add and write back; one that
// closes a block also goes through the bit-serial divider, one quotient bit per
// cycle for the three channels together. A finished result waits in an output
// register, so the next pixel is accepted while it is pending. Any write to a
// known register restarts the image; the user must write registers only while
// no pixel is in progress, which the block does not enforce. No clearing pass is
// needed: the first pixel of a column's band overwrites the stored sum.
module box_average_downscaler_core import bxd_pkg::*; (
   input logic     clock,
   input logic     reset,
   bxd_req_if.sink req,
   bxd_rsp_if.source rsp,
   bxd_csr_if.sink csr
);

   bxd_cmd_type    cmd;
   bxd_status_type status;

   assign csr.ready = 1'b1;

   bxd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bxd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr.valid && csr.ready),
      .csr_index (csr.index),
      .csr_data  (csr.data),
      .red_in    (req.red_in),
      .green_in  (req.green_in),
      .blue_in   (req.blue_in),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .red_avg   (rsp.red_avg),
      .green_avg (rsp.green_avg),
      .blue_avg  (rsp.blue_avg),
      .row_end   (rsp.row_end),
      .image_end (rsp.image_end)
   );

   // An accepted word is always followed by its accumulate step
   assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> cmd.update)
      else $error("accepted pixel was not accumulated");

   // A pending result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp.valid || rsp.ready))
      else $error("output register overwritten while pending");

   // A pixel that closes no block frees the input right away
   assert property (@(posedge clock) disable iff (reset)
      (cmd.update && !status.emit) |=> req.ready)
      else $error("input not ready after a non-emitting pixel");

   // The divider never runs while a pixel is being taken
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_run |-> !req.ready)
      else $error("divider running while input is open");

endmodule
